### rtl/core/triangle_tangent_from_uv_core_defines.svh
// Assertion macros shared by the triangle tangent core.
// Depends on nothing; included by the modules that carry assertions.
`ifndef TRIANGLE_TANGENT_FROM_UV_CORE_DEFINES_SVH
`define TRIANGLE_TANGENT_FROM_UV_CORE_DEFINES_SVH

// same-cycle implication
`define TTUV_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ttuv assertion failed");

// next-cycle implication
`define TTUV_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ttuv assertion failed");

`endif

### rtl/core/ttuv_pkg.sv
// Types and constants of the triangle tangent core.
// No dependencies; used by ttuv_ctrl, ttuv_dp and the top level.
`default_nettype none

package ttuv_pkg;

    localparam int IDX_W   = 16;
    localparam int POS_W   = 32;
    localparam int UV_W    = 20;
    localparam int OUT_W   = 16;

    localparam int DP_W    = POS_W + 1;
    localparam int DUV_W   = UV_W + 1;
    localparam int T_W     = DUV_W + DP_W + 1;
    localparam int DET_W   = 2 * DUV_W + 1;
    localparam int MA_W    = (DUV_W > 31) ? DUV_W : 31;
    localparam int MB_W    = (DP_W > 31) ? DP_W : 31;
    localparam int PROD_W  = MA_W + MB_W;
    localparam int NORM_W  = 30;
    localparam int SUM_W   = 2 * NORM_W + 2;
    localparam int ROOT_W  = NORM_W + 1;
    localparam int QUO_W   = OUT_W + 1;
    localparam int NUM_W   = NORM_W + OUT_W + 1;
    localparam int DREM_W  = ROOT_W + 1;
    localparam int STEP_W  = 6;
    localparam int MUL_STEPS  = 8;
    localparam int SQ_STEPS   = 3;
    localparam int SQRT_STEPS = SUM_W / 2;

    typedef struct packed {
        logic        [IDX_W-1:0] vertex_index;
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic signed [POS_W-1:0] pos_z;
        logic signed [UV_W-1:0]  tex_u;
        logic signed [UV_W-1:0]  tex_v;
    } t_in_beat;

    typedef struct packed {
        logic        [IDX_W-1:0] index_a;
        logic        [IDX_W-1:0] index_b;
        logic        [IDX_W-1:0] index_c;
        logic signed [OUT_W-1:0] tangent_x;
        logic signed [OUT_W-1:0] tangent_y;
        logic signed [OUT_W-1:0] tangent_z;
        logic                    degenerate;
    } t_out_beat;

    typedef enum logic [3:0] {
        S_IDLE, S_MUL, S_CHECK, S_ABS, S_NORM, S_SQUARE, S_SQRT,
        S_DIV_LOAD, S_DIV, S_DIV_STORE, S_EMIT
    } t_state;

    typedef enum logic [3:0] {
        OP_NONE, OP_CAPTURE, OP_MUL, OP_CHECK, OP_ABS, OP_SHR, OP_SHL,
        OP_SQUARE, OP_SQRT_INIT, OP_SQRT_STEP, OP_DIV_LOAD, OP_DIV_STEP,
        OP_DIV_STORE, OP_EMIT
    } t_op;

    typedef struct packed {
        t_op              op;
        logic [1:0]       sel;
        logic [STEP_W-1:0] step;
    } t_cmd;

    typedef struct packed {
        logic degen;
        logic need_shr;
        logic need_shl;
        logic out_busy;
    } t_status;

endpackage

`default_nettype wire

### rtl/core/ttuv_ctrl.sv
// Sequencer of the triangle tangent core: corner count and compute phases.
// Depends on ttuv_pkg and the assertion macros header.
`default_nettype none
`include "triangle_tangent_from_uv_core_defines.svh"

module ttuv_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_stall,
    input  wire ttuv_pkg::t_status i_status,
    output ttuv_pkg::t_cmd        o_cmd
);

    localparam int STEP_W = ttuv_pkg::STEP_W;

    ttuv_pkg::t_state  r_state, n_state;
    logic [1:0]        r_corner, n_corner;
    logic [1:0]        r_comp, n_comp;
    logic [STEP_W-1:0] r_step, n_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ttuv_pkg::S_IDLE;
            r_corner <= '0;
            r_comp   <= '0;
            r_step   <= '0;
        end else begin
            r_state  <= n_state;
            r_corner <= n_corner;
            r_comp   <= n_comp;
            r_step   <= n_step;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_corner   = r_corner;
        n_comp     = r_comp;
        n_step     = r_step;
        o_cmd.op   = ttuv_pkg::OP_NONE;
        o_cmd.sel  = r_comp;
        o_cmd.step = r_step;
        o_in_stall = (r_state != ttuv_pkg::S_IDLE);
        case (r_state)
            ttuv_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.op  = ttuv_pkg::OP_CAPTURE;
                    o_cmd.sel = r_corner;
                    if (r_corner == 2'd2) begin
                        n_corner = '0;
                        n_step   = '0;
                        n_state  = ttuv_pkg::S_MUL;
                    end else begin
                        n_corner = r_corner + 2'd1;
                    end
                end
            end
            ttuv_pkg::S_MUL: begin
                o_cmd.op = ttuv_pkg::OP_MUL;
                if (r_step == STEP_W'(ttuv_pkg::MUL_STEPS)) begin
                    n_step  = '0;
                    n_state = ttuv_pkg::S_CHECK;
                end else begin
                    n_step = r_step + STEP_W'(1);
                end
            end
            ttuv_pkg::S_CHECK: begin
                o_cmd.op = ttuv_pkg::OP_CHECK;
                n_state  = i_status.degen ? ttuv_pkg::S_EMIT : ttuv_pkg::S_ABS;
            end
            ttuv_pkg::S_ABS: begin
                o_cmd.op = ttuv_pkg::OP_ABS;
                n_state  = ttuv_pkg::S_NORM;
            end
            ttuv_pkg::S_NORM: begin
                // bring the largest magnitude to exactly NORM_W bits
                if (i_status.need_shr) begin
                    o_cmd.op = ttuv_pkg::OP_SHR;
                end else if (i_status.need_shl) begin
                    o_cmd.op = ttuv_pkg::OP_SHL;
                end else begin
                    n_step  = '0;
                    n_state = ttuv_pkg::S_SQUARE;
                end
            end
            ttuv_pkg::S_SQUARE: begin
                o_cmd.op = ttuv_pkg::OP_SQUARE;
                if (r_step == STEP_W'(ttuv_pkg::SQ_STEPS)) begin
                    n_step  = '0;
                    n_state = ttuv_pkg::S_SQRT;
                end else begin
                    n_step = r_step + STEP_W'(1);
                end
            end
            ttuv_pkg::S_SQRT: begin
                o_cmd.op = (r_step == '0) ? ttuv_pkg::OP_SQRT_INIT : ttuv_pkg::OP_SQRT_STEP;
                if (r_step == STEP_W'(ttuv_pkg::SQRT_STEPS)) begin
                    n_step  = '0;
                    n_comp  = '0;
                    n_state = ttuv_pkg::S_DIV_LOAD;
                end else begin
                    n_step = r_step + STEP_W'(1);
                end
            end
            ttuv_pkg::S_DIV_LOAD: begin
                o_cmd.op = ttuv_pkg::OP_DIV_LOAD;
                n_step   = '0;
                n_state  = ttuv_pkg::S_DIV;
            end
            ttuv_pkg::S_DIV: begin
                o_cmd.op = ttuv_pkg::OP_DIV_STEP;
                if (r_step == STEP_W'(ttuv_pkg::QUO_W - 1)) begin
                    n_step  = '0;
                    n_state = ttuv_pkg::S_DIV_STORE;
                end else begin
                    n_step = r_step + STEP_W'(1);
                end
            end
            ttuv_pkg::S_DIV_STORE: begin
                o_cmd.op = ttuv_pkg::OP_DIV_STORE;
                if (r_comp == 2'd2) begin
                    n_state = ttuv_pkg::S_EMIT;
                end else begin
                    n_comp  = r_comp + 2'd1;
                    n_state = ttuv_pkg::S_DIV_LOAD;
                end
            end
            ttuv_pkg::S_EMIT: begin
                // hold until the output register frees up
                if (!i_status.out_busy) begin
                    o_cmd.op = ttuv_pkg::OP_EMIT;
                    n_state  = ttuv_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = ttuv_pkg::S_IDLE;
            end
        endcase
    end

    `TTUV_ASSERT_IMP(a_corner_range, i_clk, i_rst_n, 1'b1, r_corner != 2'd3)
    `TTUV_ASSERT_NXT(a_third_starts, i_clk, i_rst_n, r_state == ttuv_pkg::S_IDLE && i_in_valid && r_corner == 2'd2, r_state == ttuv_pkg::S_MUL && r_step == '0 && r_corner == 2'd0)
    `TTUV_ASSERT_NXT(a_emit_returns, i_clk, i_rst_n, r_state == ttuv_pkg::S_EMIT && !i_status.out_busy, r_state == ttuv_pkg::S_IDLE)

endmodule

`default_nettype wire

### rtl/core/ttuv_dp.sv
// Datapath of the triangle tangent core: corner store, shared multiplier,
// normalizer, bit-serial square root and divider, output register. Uses ttuv_pkg.
`default_nettype none

module ttuv_dp (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire ttuv_pkg::t_cmd      i_cmd,
    output ttuv_pkg::t_status        o_status,
    input  wire ttuv_pkg::t_in_beat  i_in_data,
    output logic                     o_out_valid,
    input  wire logic                i_out_stall,
    output ttuv_pkg::t_out_beat      o_out_data
);

    localparam int IDX_W  = ttuv_pkg::IDX_W;
    localparam int POS_W  = ttuv_pkg::POS_W;
    localparam int UV_W   = ttuv_pkg::UV_W;
    localparam int OUT_W  = ttuv_pkg::OUT_W;
    localparam int DP_W   = ttuv_pkg::DP_W;
    localparam int DUV_W  = ttuv_pkg::DUV_W;
    localparam int T_W    = ttuv_pkg::T_W;
    localparam int DET_W  = ttuv_pkg::DET_W;
    localparam int MA_W   = ttuv_pkg::MA_W;
    localparam int MB_W   = ttuv_pkg::MB_W;
    localparam int PROD_W = ttuv_pkg::PROD_W;
    localparam int NORM_W = ttuv_pkg::NORM_W;
    localparam int SUM_W  = ttuv_pkg::SUM_W;
    localparam int ROOT_W = ttuv_pkg::ROOT_W;
    localparam int QUO_W  = ttuv_pkg::QUO_W;
    localparam int NUM_W  = ttuv_pkg::NUM_W;
    localparam int DREM_W = ttuv_pkg::DREM_W;
    localparam logic [OUT_W-1:0] PMAX = {1'b0, {(OUT_W-1){1'b1}}};

    // corner store
    logic        [IDX_W-1:0] r_idx [3];
    logic signed [POS_W-1:0] r_pos [3][3];
    logic signed [UV_W-1:0]  r_uv  [3][2];

    // arithmetic state
    logic signed [PROD_W-1:0] r_prod;
    logic signed [DET_W-1:0]  r_det;
    logic signed [T_W-1:0]    r_t    [3];
    logic        [T_W-1:0]    r_mag  [3];
    logic                     r_neg  [3];
    logic                     r_degen;
    logic        [SUM_W-1:0]  r_sum;
    logic        [SUM_W-1:0]  r_rem;
    logic        [SUM_W-1:0]  r_root;
    logic        [SUM_W-1:0]  r_bit;
    logic        [DREM_W-1:0] r_drem;
    logic        [QUO_W-1:0]  r_nlow;
    logic        [QUO_W-1:0]  r_q;
    logic        [OUT_W-1:0]  r_res  [3];

    logic                      r_out_valid;
    ttuv_pkg::t_out_beat       r_out_data;

    logic signed [DP_W-1:0]   dp1 [3];
    logic signed [DP_W-1:0]   dp2 [3];
    logic signed [DUV_W-1:0]  du1, dv1, du2, dv2;
    logic signed [MA_W-1:0]   mul_a;
    logic signed [MB_W-1:0]   mul_b;
    logic        [T_W-1:0]    or_all;
    logic                     degen_now;
    logic        [SUM_W-1:0]  trial;
    logic        [NUM_W-1:0]  num;
    logic        [DREM_W:0]   rem2;
    logic        [DREM_W:0]   divisor;
    logic                     qbit;
    logic        [QUO_W-1:0]  q_neg;
    logic        [OUT_W-1:0]  res_now;
    logic signed [POS_W-1:0]  in_pos [3];

    always_comb begin
        in_pos[0] = i_in_data.pos_x;
        in_pos[1] = i_in_data.pos_y;
        in_pos[2] = i_in_data.pos_z;
        for (int k = 0; k < 3; k++) begin
            dp1[k] = DP_W'(r_pos[1][k]) - DP_W'(r_pos[0][k]);
            dp2[k] = DP_W'(r_pos[2][k]) - DP_W'(r_pos[0][k]);
        end
        du1 = DUV_W'(r_uv[1][0]) - DUV_W'(r_uv[0][0]);
        dv1 = DUV_W'(r_uv[1][1]) - DUV_W'(r_uv[0][1]);
        du2 = DUV_W'(r_uv[2][0]) - DUV_W'(r_uv[0][0]);
        dv2 = DUV_W'(r_uv[2][1]) - DUV_W'(r_uv[0][1]);
    end

    // operand select for the shared multiplier
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (i_cmd.op)
            ttuv_pkg::OP_MUL: begin
                case (i_cmd.step)
                    6'd0: begin mul_a = MA_W'(du1); mul_b = MB_W'(dv2);    end
                    6'd1: begin mul_a = MA_W'(dv1); mul_b = MB_W'(du2);    end
                    6'd2: begin mul_a = MA_W'(dv2); mul_b = MB_W'(dp1[0]); end
                    6'd3: begin mul_a = MA_W'(dv1); mul_b = MB_W'(dp2[0]); end
                    6'd4: begin mul_a = MA_W'(dv2); mul_b = MB_W'(dp1[1]); end
                    6'd5: begin mul_a = MA_W'(dv1); mul_b = MB_W'(dp2[1]); end
                    6'd6: begin mul_a = MA_W'(dv2); mul_b = MB_W'(dp1[2]); end
                    6'd7: begin mul_a = MA_W'(dv1); mul_b = MB_W'(dp2[2]); end
                    default: begin mul_a = '0; mul_b = '0; end
                endcase
            end
            ttuv_pkg::OP_SQUARE: begin
                if (i_cmd.step[1:0] != 2'd3) begin
                    mul_a = MA_W'({1'b0, r_mag[i_cmd.step[1:0]][NORM_W-1:0]});
                    mul_b = MB_W'({1'b0, r_mag[i_cmd.step[1:0]][NORM_W-1:0]});
                end
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb begin
        or_all    = r_mag[0] | r_mag[1] | r_mag[2];
        degen_now = (r_det == '0) || ((r_t[0] == '0) && (r_t[1] == '0) && (r_t[2] == '0));
        trial     = r_root + r_bit;
        num       = NUM_W'({r_mag[i_cmd.sel][NORM_W-1:0], {(OUT_W-1){1'b0}}})
                  + NUM_W'(r_root[ROOT_W-1:1]);
        rem2      = {r_drem, r_nlow[QUO_W-1]};
        divisor   = (DREM_W+1)'(r_root[ROOT_W-1:0]);
        qbit      = (rem2 >= divisor);
        q_neg     = ~r_q + QUO_W'(1);
        if (r_neg[i_cmd.sel]) begin
            res_now = q_neg[OUT_W-1:0];
        end else if (r_q[QUO_W-1:OUT_W-1] != '0) begin
            res_now = PMAX;
        end else begin
            res_now = r_q[OUT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
        case (i_cmd.op)
            ttuv_pkg::OP_CAPTURE: begin
                r_idx[i_cmd.sel] <= i_in_data.vertex_index;
                for (int k = 0; k < 3; k++) begin
                    r_pos[i_cmd.sel][k] <= in_pos[k];
                end
                r_uv[i_cmd.sel][0] <= i_in_data.tex_u;
                r_uv[i_cmd.sel][1] <= i_in_data.tex_v;
            end
            ttuv_pkg::OP_MUL: begin
                // accumulate the registered product of the previous step
                case (i_cmd.step)
                    6'd1: r_det  <= DET_W'(r_prod);
                    6'd2: r_det  <= r_det - DET_W'(r_prod);
                    6'd3: r_t[0] <= T_W'(r_prod);
                    6'd4: r_t[0] <= r_t[0] - T_W'(r_prod);
                    6'd5: r_t[1] <= T_W'(r_prod);
                    6'd6: r_t[1] <= r_t[1] - T_W'(r_prod);
                    6'd7: r_t[2] <= T_W'(r_prod);
                    6'd8: r_t[2] <= r_t[2] - T_W'(r_prod);
                    default: begin end
                endcase
            end
            ttuv_pkg::OP_CHECK: begin
                r_degen <= degen_now;
            end
            ttuv_pkg::OP_ABS: begin
                for (int k = 0; k < 3; k++) begin
                    r_mag[k] <= r_t[k][T_W-1] ? T_W'(-r_t[k]) : T_W'(r_t[k]);
                    r_neg[k] <= r_t[k][T_W-1] ^ r_det[DET_W-1];
                end
            end
            ttuv_pkg::OP_SHR: begin
                for (int k = 0; k < 3; k++) r_mag[k] <= r_mag[k] >> 1;
            end
            ttuv_pkg::OP_SHL: begin
                for (int k = 0; k < 3; k++) r_mag[k] <= r_mag[k] << 1;
            end
            ttuv_pkg::OP_SQUARE: begin
                case (i_cmd.step)
                    6'd1:    r_sum <= SUM_W'(r_prod);
                    6'd2,
                    6'd3:    r_sum <= r_sum + SUM_W'(r_prod);
                    default: begin end
                endcase
            end
            ttuv_pkg::OP_SQRT_INIT: begin
                r_rem  <= r_sum;
                r_root <= '0;
                r_bit  <= {2'b01, {(SUM_W-2){1'b0}}};
            end
            ttuv_pkg::OP_SQRT_STEP: begin
                if (r_rem >= trial) begin
                    r_rem  <= r_rem - trial;
                    r_root <= (r_root >> 1) + r_bit;
                end else begin
                    r_root <= r_root >> 1;
                end
                r_bit <= r_bit >> 2;
            end
            ttuv_pkg::OP_DIV_LOAD: begin
                r_drem <= DREM_W'(num[NUM_W-1:QUO_W]);
                r_nlow <= num[QUO_W-1:0];
                r_q    <= '0;
            end
            ttuv_pkg::OP_DIV_STEP: begin
                r_drem <= qbit ? DREM_W'(rem2 - divisor) : rem2[DREM_W-1:0];
                r_nlow <= r_nlow << 1;
                r_q    <= {r_q[QUO_W-2:0], qbit};
            end
            ttuv_pkg::OP_DIV_STORE: begin
                r_res[i_cmd.sel] <= res_now;
            end
            ttuv_pkg::OP_EMIT: begin
                r_out_data.index_a    <= r_idx[0];
                r_out_data.index_b    <= r_idx[1];
                r_out_data.index_c    <= r_idx[2];
                r_out_data.tangent_x  <= r_degen ? '0 : r_res[0];
                r_out_data.tangent_y  <= r_degen ? '0 : r_res[1];
                r_out_data.tangent_z  <= r_degen ? '0 : r_res[2];
                r_out_data.degenerate <= r_degen;
            end
            default: begin end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.op == ttuv_pkg::OP_EMIT) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_status.degen    = degen_now;
    assign o_status.need_shr = |or_all[T_W-1:NORM_W];
    assign o_status.need_shl = !or_all[NORM_W-1];
    assign o_status.out_busy = r_out_valid & i_out_stall;
    assign o_out_valid       = r_out_valid;
    assign o_out_data        = r_out_data;

endmodule

`default_nettype wire

### rtl/core/triangle_tangent_from_uv_core.sv
// Triangle tangent core, top level: joins sequencer and datapath.
// Depends on ttuv_pkg, ttuv_ctrl and ttuv_dp.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in_data) takes triangle corners
//   in order, three per triangle. The first two corners are taken one per
//   cycle. The third closes the triangle and starts the computation; the
//   input stalls until the result beat is loaded into the output register.
//   Output channel (o_out_valid / i_out_stall / o_out_data) carries one beat
//   per triangle: the three indices, the unit tangent in Q1.15 and a
//   degenerate flag (tangent zero when the UV determinant or tangent is zero).
//   The result follows the third corner once the compute phases are done:
//   for a degenerate triangle the products and the check, otherwise also
//   the normalizing shifter (one bit per cycle, up to 29 shifts), the square
//   root (one result bit per cycle, 31 steps) and three 17-step restoring
//   divisions on one shared divider.
//   A new triangle's first two corners are accepted while a result still
//   waits; a stalled result is held until taken, and a finished one waits
//   for the output register. Synchronous reset clears the corner count,
//   the sequencer and the output valid.
`default_nettype none

module triangle_tangent_from_uv_core (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire ttuv_pkg::t_in_beat i_in_data,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output ttuv_pkg::t_out_beat     o_out_data
);

    ttuv_pkg::t_cmd    cmd;
    ttuv_pkg::t_status status;

    ttuv_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    ttuv_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

`default_nettype wire

### sim/triangle_tangent_from_uv_core_test.sv
// Testbench for the triangle tangent core: drives triangle corners, predicts
// each face tangent in fixed point and checks every result beat in order.
// Depends on ttuv_pkg and triangle_tangent_from_uv_core.
`timescale 1ns / 1ps

module triangle_tangent_from_uv_core_test;

    localparam int CYCLE_LIMIT = 2000000;
    localparam int RANDOM_CORNERS = 1500;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_stall;
    ttuv_pkg::t_in_beat  in_data = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    ttuv_pkg::t_out_beat out_data;

    always #2 i_clk = ~i_clk;

    triangle_tangent_from_uv_core i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_in_data  (in_data),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out_data (out_data)
    );

    // predictor state
    int                  corner_cnt = 0;
    ttuv_pkg::t_in_beat  held_corner [2];
    ttuv_pkg::t_out_beat tangent_queue [$];
    int                  mismatches = 0;
    int                  cycle_cnt = 0;
    int                  send_idle_pct = 0;
    int                  recv_stall_pct = 0;

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch %s: got %0h expected %0h", what, got, want);
        mismatches++;
    endtask

    function automatic logic [29:0] scale30(input logic [127:0] a, input int len);
        if (len <= 30) return 30'(a << (30 - len));
        return 30'(a >> (len - 30));
    endfunction

    function automatic logic [63:0] root64(input logic [63:0] x);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x) b = b >> 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic ttuv_pkg::t_out_beat face_tangent(input ttuv_pkg::t_in_beat c0,
                                                         input ttuv_pkg::t_in_beat c1,
                                                         input ttuv_pkg::t_in_beat c2);
        ttuv_pkg::t_out_beat r;
        logic signed [127:0] dp1 [3];
        logic signed [127:0] dp2 [3];
        logic signed [127:0] t [3];
        logic signed [127:0] du1, dv1, du2, dv2, det;
        logic [127:0] a [3];
        logic [63:0] mg [3];
        logic [63:0] sum, root, q;
        logic flip, degen;
        int len;
        dp1[0] = 128'(c1.pos_x) - 128'(c0.pos_x);
        dp1[1] = 128'(c1.pos_y) - 128'(c0.pos_y);
        dp1[2] = 128'(c1.pos_z) - 128'(c0.pos_z);
        dp2[0] = 128'(c2.pos_x) - 128'(c0.pos_x);
        dp2[1] = 128'(c2.pos_y) - 128'(c0.pos_y);
        dp2[2] = 128'(c2.pos_z) - 128'(c0.pos_z);
        du1 = 128'(c1.tex_u) - 128'(c0.tex_u);
        dv1 = 128'(c1.tex_v) - 128'(c0.tex_v);
        du2 = 128'(c2.tex_u) - 128'(c0.tex_u);
        dv2 = 128'(c2.tex_v) - 128'(c0.tex_v);
        det = du1 * dv2 - dv1 * du2;
        flip = det < 0;
        degen = det == 0;
        len = 0;
        for (int k = 0; k < 3; k++) begin
            t[k] = dv2 * dp1[k] - dv1 * dp2[k];
            a[k] = t[k] < 0 ? 128'(-t[k]) : 128'(t[k]);
            for (int b = 0; b < 128; b++) if (a[k][b] && b + 1 > len) len = b + 1;
        end
        if (len == 0) degen = 1'b1;
        r = '0;
        r.index_a = c0.vertex_index;
        r.index_b = c1.vertex_index;
        r.index_c = c2.vertex_index;
        r.degenerate = degen;
        if (!degen) begin
            sum = 0;
            for (int k = 0; k < 3; k++) begin
                mg[k] = 64'(scale30(a[k], len));
                sum += mg[k] * mg[k];
            end
            root = root64(sum);
            for (int k = 0; k < 3; k++) begin
                logic [15:0] v;
                q = ((mg[k] << (ttuv_pkg::OUT_W - 1)) + (root >> 1)) / root;
                if ((t[k] < 0) != flip) v = 16'(-q);
                else v = q > 64'd32767 ? 16'h7fff : 16'(q);
                if (k == 0) r.tangent_x = v;
                else if (k == 1) r.tangent_y = v;
                else r.tangent_z = v;
            end
        end
        return r;
    endfunction

    // update the predictor with one accepted corner
    task automatic take_corner(input ttuv_pkg::t_in_beat c);
        if (corner_cnt < 2) begin
            held_corner[corner_cnt] = c;
            corner_cnt++;
        end else begin
            tangent_queue.insert(tangent_queue.size(),
                                 face_tangent(held_corner[0], held_corner[1], c));
            corner_cnt = 0;
        end
    endtask

    always @(posedge i_clk) begin
        ttuv_pkg::t_out_beat want;
        cycle_cnt <= cycle_cnt + 1;
        if (i_rst_n && in_valid && !in_stall) take_corner(in_data);
        if (i_rst_n && out_valid && !out_stall) begin
            if (tangent_queue.size() == 0) begin
                report_mismatch("unexpected beat", 64'(out_data.index_a), 64'd0);
            end else begin
                want = tangent_queue.pop_front();
                if (out_data.index_a !== want.index_a)
                    report_mismatch("index_a", 64'(out_data.index_a), 64'(want.index_a));
                if (out_data.index_b !== want.index_b)
                    report_mismatch("index_b", 64'(out_data.index_b), 64'(want.index_b));
                if (out_data.index_c !== want.index_c)
                    report_mismatch("index_c", 64'(out_data.index_c), 64'(want.index_c));
                if (out_data.tangent_x !== want.tangent_x)
                    report_mismatch("tangent_x", 64'(out_data.tangent_x),
                                    64'(want.tangent_x));
                if (out_data.tangent_y !== want.tangent_y)
                    report_mismatch("tangent_y", 64'(out_data.tangent_y),
                                    64'(want.tangent_y));
                if (out_data.tangent_z !== want.tangent_z)
                    report_mismatch("tangent_z", 64'(out_data.tangent_z),
                                    64'(want.tangent_z));
                if (out_data.degenerate !== want.degenerate)
                    report_mismatch("degenerate", 64'(out_data.degenerate),
                                    64'(want.degenerate));
            end
        end
    end

    // receiver stalls at random, changed on the falling edge
    always @(negedge i_clk)
        out_stall <= ($urandom_range(99) < recv_stall_pct);

    always @(posedge i_clk) begin
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("triangle_tangent_from_uv_core_test NOT OK");
            $finish;
        end
    end

    function automatic logic [31:0] rand_pos(input int mode);
        case (mode)
            0: return 32'($urandom_range(255)) - 32'd128;
            1: return $urandom;
            2: return {{12{1'($urandom_range(1))}}, 20'($urandom)};
            default: return $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
        endcase
    endfunction

    function automatic logic [19:0] rand_uv(input int mode);
        case (mode)
            0: return 20'($urandom_range(15)) - 20'd8;
            1: return 20'($urandom);
            default: return $urandom_range(1) ? 20'h7ffff : 20'h80000;
        endcase
    endfunction

    function automatic ttuv_pkg::t_in_beat rand_corner(input int pm, input int um);
        ttuv_pkg::t_in_beat c;
        c.vertex_index = 16'($urandom);
        c.pos_x = rand_pos(pm);
        c.pos_y = rand_pos(pm);
        c.pos_z = rand_pos(pm);
        c.tex_u = rand_uv(um);
        c.tex_v = rand_uv(um);
        return c;
    endfunction

    // present one corner and hold it until taken; drop valid only while idle
    task automatic send_corner(input ttuv_pkg::t_in_beat c);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge i_clk);
        end
        in_data <= c;
        in_valid <= 1'b1;
        @(posedge i_clk);
        while (in_stall) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // directed corners: three rows per triangle
    localparam int DIRECTED_ROWS = 21;
    ttuv_pkg::t_in_beat directed_rows [DIRECTED_ROWS] = '{
        // ordinary unit triangle
        '{16'd0, 32'h0, 32'h0, 32'h0, 20'h0, 20'h0},
        '{16'd1, 32'h10000, 32'h0, 32'h0, 20'h10000, 20'h0},
        '{16'd2, 32'h0, 32'h10000, 32'h0, 20'h0, 20'h10000},
        // zero UV determinant
        '{16'hffff, 32'h0, 32'h0, 32'h0, 20'h1, 20'h1},
        '{16'h1234, 32'h10000, 32'h0, 32'h0, 20'h1, 20'h1},
        '{16'h0, 32'h0, 32'h10000, 32'h0, 20'h1, 20'h1},
        // zero tangent: all positions equal
        '{16'h8000, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 20'h0, 20'h0},
        '{16'h7fff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 20'h10000, 20'h0},
        '{16'h0001, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 20'h0, 20'h10000},
        // extremes, negative determinant
        '{16'h5555, 32'h80000000, 32'h80000000, 32'h80000000, 20'h80000, 20'h80000},
        '{16'haaaa, 32'h7fffffff, 32'h7fffffff, 32'h80000000, 20'h80000, 20'h7ffff},
        '{16'hffff, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 20'h7ffff, 20'h80000},
        // tiny edges, shifted left
        '{16'd10, 32'h0, 32'h0, 32'h0, 20'h0, 20'h0},
        '{16'd11, 32'h1, 32'h0, 32'h0, 20'h1, 20'h0},
        '{16'd12, 32'h0, 32'h1, 32'h0, 20'h0, 20'h1},
        // single axis, saturating positive
        '{16'd20, 32'h0, 32'h0, 32'h0, 20'h0, 20'h0},
        '{16'd21, 32'h0, 32'h0, 32'h1000, 20'h1, 20'h0},
        '{16'd22, 32'h0, 32'h0, 32'h0, 20'h0, 20'h1},
        // single axis negative
        '{16'd30, 32'h0, 32'h0, 32'h0, 20'h0, 20'h0},
        '{16'd31, 32'h0, 32'h0, 32'hfffff000, 20'h1, 20'h0},
        '{16'd32, 32'h0, 32'h0, 32'h0, 20'h0, 20'h1}
    };

    // results readable at a glance: degenerate rows give zero tangents, the single-axis row saturates
    initial begin
        ttuv_pkg::t_out_beat quick [3];
        quick[0] = '{16'hffff, 16'h1234, 16'h0, 16'sh0, 16'sh0, 16'sh0, 1'b1};
        quick[1] = '{16'h8000, 16'h7fff, 16'h0001, 16'sh0, 16'sh0, 16'sh0, 1'b1};
        quick[2] = '{16'd20, 16'd21, 16'd22, 16'sh0, 16'sh0, 16'sh7fff, 1'b0};
        if (face_tangent(directed_rows[3], directed_rows[4], directed_rows[5]) !== quick[0]
            || face_tangent(directed_rows[6], directed_rows[7], directed_rows[8])
               !== quick[1]
            || face_tangent(directed_rows[15], directed_rows[16], directed_rows[17])
               !== quick[2])
            report_mismatch("predictor table row", 64'd0, 64'd0);
    end

    initial begin
        int pm, um;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        for (int r = 0; r < DIRECTED_ROWS; r++) send_corner(directed_rows[r]);
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 79; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 79; end
                default: begin send_idle_pct = 19; recv_stall_pct = 19; end
            endcase
            for (int n = 0; n < RANDOM_CORNERS / 12; n++) begin
                pm = $urandom_range(3);
                um = $urandom_range(9) == 0 ? 2 : $urandom_range(1);
                for (int c = 0; c < 3; c++) send_corner(rand_corner(pm, um));
                // hold off until every result is in
                if (n == 20) begin
                    in_valid <= 1'b0;
                    while (tangent_queue.size() != 0) @(negedge i_clk);
                end
            end
        end
        in_valid <= 1'b0;
        recv_stall_pct = 0;
        while (tangent_queue.size() != 0) @(negedge i_clk);
        repeat (200) @(negedge i_clk);
        if (mismatches == 0 && tangent_queue.size() == 0)
            $display("triangle_tangent_from_uv_core_test OK");
        else
            $display("triangle_tangent_from_uv_core_test NOT OK");
        $finish;
    end
endmodule
